### hw/rtl/record_stack_with_sort_assert.svh
// Assertion macros used by the record stack checker.
`ifndef RECORD_STACK_WITH_SORT_ASSERT_SVH
`define RECORD_STACK_WITH_SORT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record stack check failed");

// Next-cycle implication, disabled while reset is low.
`define RSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record stack check failed");

`endif

### hw/rtl/rss_pkg.sv
// Types, constants and codes for the record stack.
package rss_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REC_W  = 48;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_SHOW = 2'd2,
    MODE_SORT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SHOW,
    S_SORT_I,
    S_SORT_J,
    S_SORT_WI
  } state_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [15:0] grade;
  } rec_t;

  typedef struct packed {
    logic    valid;
    rec_t    rec;
    status_t status;
    logic    last;
  } emit_t;

endpackage

### hw/rtl/rss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/rss_ctrl.sv
// Sequencer: push, pop, display walk and exchange sort over the record RAM.
module rss_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rss_pkg::mode_t             in_mode,
  input  rss_pkg::rec_t              in_rec,
  input  logic                       out_free,
  output rss_pkg::emit_t             emit,
  output logic                       ram_wr_en,
  output logic [rss_pkg::ADDR_W-1:0] ram_wr_addr,
  output rss_pkg::rec_t              ram_wr_data,
  output logic                       ram_rd_en,
  output logic [rss_pkg::ADDR_W-1:0] ram_rd_addr,
  input  rss_pkg::rec_t              ram_rd_data
);

  import rss_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  j_r, j_nxt;
  rec_t               cur_r, cur_nxt;
  logic               accept;
  logic               empty;
  logic               full;
  logic               i_last;
  logic               j_more;
  logic               swap;

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  // outer index has no partner above it: sort is finished
  assign i_last   = (CNT_W'(idx_r) + CNT_W'(1)) >= count_r;
  assign j_more   = (CNT_W'(j_r) + CNT_W'(1)) < count_r;
  assign swap     = cur_r.grade < ram_rd_data.grade;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !empty) begin
          unique case (in_mode)
            MODE_PUSH: state_nxt = S_IDLE;
            MODE_POP:  state_nxt = S_POP;
            MODE_SHOW: state_nxt = S_SHOW;
            MODE_SORT: state_nxt = S_SORT_I;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_SHOW: begin
        if (out_free && idx_r == '0) state_nxt = S_IDLE;
      end
      S_SORT_I: begin
        if (!i_last) begin
          state_nxt = S_SORT_J;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SORT_J: begin
        if (!j_more) state_nxt = S_SORT_WI;
      end
      S_SORT_WI: state_nxt = S_SORT_I;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit        = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = cur_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    cur_nxt     = cur_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          emit.last = 1'b1;
          unique case (in_mode)
            MODE_PUSH: begin
              emit.valid = 1'b1;
              if (full) begin
                emit.status = ST_FULL;
              end else begin
                emit.status = ST_OK;
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(count_r);
                ram_wr_data = in_rec;
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            MODE_POP: begin
              if (empty) begin
                emit.valid  = 1'b1;
                emit.status = ST_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(count_r - CNT_W'(1));
                count_nxt   = count_r - CNT_W'(1);
              end
            end
            MODE_SHOW: begin
              if (empty) begin
                emit.valid  = 1'b1;
                emit.status = ST_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(count_r - CNT_W'(1));
                idx_nxt     = ADDR_W'(count_r - CNT_W'(1));
              end
            end
            MODE_SORT: begin
              if (empty) begin
                emit.valid  = 1'b1;
                emit.status = ST_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                idx_nxt     = '0;
              end
            end
            default: emit.valid = 1'b0;
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.rec    = ram_rd_data;
          emit.status = ST_OK;
          emit.last   = 1'b1;
        end
      end
      S_SHOW: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.rec    = ram_rd_data;
          emit.status = ST_OK;
          emit.last   = (idx_r == '0);
          // fetch the next record down while this one is registered
          if (idx_r != '0) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r - ADDR_W'(1);
            idx_nxt     = idx_r - ADDR_W'(1);
          end
        end
      end
      S_SORT_I: begin
        cur_nxt = ram_rd_data;
        if (!i_last) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_r + ADDR_W'(1);
          j_nxt       = idx_r + ADDR_W'(1);
        end else if (out_free) begin
          emit.valid  = 1'b1;
          emit.status = ST_OK;
          emit.last   = 1'b1;
        end
      end
      S_SORT_J: begin
        // record i lives in cur_r; swap pushes it up to slot j
        if (swap) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = j_r;
          ram_wr_data = cur_r;
          cur_nxt     = ram_rd_data;
        end
        if (j_more) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = j_r + ADDR_W'(1);
          j_nxt       = j_r + ADDR_W'(1);
        end
      end
      S_SORT_WI: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = cur_r;
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_r + ADDR_W'(1);
        idx_nxt     = idx_r + ADDR_W'(1);
      end
      default: emit = '0;
    endcase
  end

endmodule

### hw/rtl/record_stack_with_sort.sv
// Push: result in the cycle after the request, one request per cycle while the output is not stalled.
// Pop: the record passes the registered RAM read and then the output register; no new request until it is emitted.
// Display of n records: one result per cycle after the first RAM read, while the output is not stalled.
// Sort of n records: one RAM read port per step.
// Reset clears the entry count and control only; the record RAM is not cleared.
module record_stack_with_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // grade[15:0], record_tag[47:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_grade[15:0], out_tag[47:16]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  import rss_pkg::*;

  emit_t             emit;
  logic              out_free;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  rec_t              ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [REC_W-1:0]  ram_rd_raw;
  logic              out_valid_r;
  rec_t              out_rec_r;
  status_t           out_status_r;
  logic              out_last_r;

  assign out_free = !out_valid_r || out_tready;

  rss_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (mode_t'(in_tuser)),
    .in_rec      (rec_t'(in_tdata)),
    .out_free    (out_free),
    .emit        (emit),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (rec_t'(ram_rd_raw))
  );

  rss_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (REC_W'(ram_wr_data)),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_rec_r    <= emit.rec;
      out_status_r <= emit.status;
      out_last_r   <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = REC_W'(out_rec_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/rss_checker.sv
// Port-level checks for the record stack, bound to the top level.
module rss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  import rss_pkg::*;

`include "record_stack_with_sort_assert.svh"

  // a stalled result holds its contents
  `RSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // full or empty results close their request
  `RSS_ASSERT_IMP(a_err_last, clk, rst_n, out_tvalid && out_tuser != ST_OK, out_tlast)

  // full or empty results carry no record
  `RSS_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && out_tuser != ST_OK,
    out_tdata == 48'd0)

  // a request is taken only when the result slot is free or draining
  `RSS_ASSERT_IMP(a_slot_free, clk, rst_n, in_tvalid && in_tready,
    !out_tvalid || out_tready)

endmodule

bind record_stack_with_sort rss_checker u_rss_checker (.*);
